### rtl/core/b2d_pkg.sv
package b2d_pkg;

	localparam int VALUE_W      = 27;
	localparam int DIGIT_W      = 4;
	localparam int IDX_W        = 3;
	localparam int DCNT_W       = 4;
	localparam int DCNT_RST     = 4;
	localparam int MAX_DIGITS_DEF = 8;

	// decimal digits needed to hold any VALUE_W-bit number
	localparam int VAL_DIGITS   = 9;

	// bits taken into the cell chain per cycle while a conversion runs
	localparam int BITS_PER_CYC = 4;
	localparam int STEPS        = (VALUE_W + BITS_PER_CYC - 1) / BITS_PER_CYC;
	localparam int SH_W         = STEPS * BITS_PER_CYC;
	localparam int STEP_W       = $clog2(STEPS);

	typedef struct packed {
		logic start;
		logic take;
	} conv_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_sts_t;

	function automatic int ncell_f(int max_digits);
		return (max_digits > VAL_DIGITS) ? max_digits : VAL_DIGITS;
	endfunction

endpackage

### rtl/core/b2d_cell.sv
module b2d_cell (
	input  logic                              clk,
	input  logic                              clr,
	input  logic                              en,
	input  logic [b2d_pkg::BITS_PER_CYC-1:0]  shin,
	output logic [b2d_pkg::BITS_PER_CYC-1:0]  shout,
	output logic [b2d_pkg::DIGIT_W-1:0]       digit
);
	import b2d_pkg::*;

	logic [DIGIT_W-1:0] dig_q;
	logic [DIGIT_W-1:0] dig_nxt;

	// add 3 when five or more, then shift; bit j of shin/shout is step j
	always_comb begin
		dig_nxt = dig_q;
		shout   = '0;
		for (int j = 0; j < BITS_PER_CYC; j++) begin
			if (dig_nxt >= DIGIT_W'(5)) begin
				dig_nxt = dig_nxt + DIGIT_W'(3);
			end
			shout[j] = dig_nxt[DIGIT_W-1];
			dig_nxt  = {dig_nxt[DIGIT_W-2:0], shin[j]};
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			dig_q <= '0;
		end else if (en) begin
			dig_q <= dig_nxt;
		end
	end

	assign digit = dig_q;

endmodule

### rtl/core/b2d_conv.sv
module b2d_conv #(
	parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF,
	localparam int NCELL = b2d_pkg::ncell_f(MAX_DIGITS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  b2d_pkg::conv_ctl_t                    ctl,
	input  logic [b2d_pkg::VALUE_W-1:0]           value,
	output b2d_pkg::conv_sts_t                    sts,
	output logic [NCELL-1:0][b2d_pkg::DIGIT_W-1:0] digits
);
	import b2d_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SH_W-1:0]   sh_q;

	logic [NCELL:0][BITS_PER_CYC-1:0] link;

	// first step of a cycle takes the most significant remaining bit
	always_comb begin
		for (int j = 0; j < BITS_PER_CYC; j++) begin
			link[0][j] = sh_q[SH_W-1-j];
		end
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		b2d_cell u_cell (
			.clk   (clk),
			.clr   (ctl.start),
			.en    (run_q),
			.shin  (link[g]),
			.shout (link[g+1]),
			.digit (digits[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (ctl.take) begin
				done_q <= 1'b0;
			end
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			sh_q <= SH_W'(value);
		end else if (run_q) begin
			sh_q <= sh_q << BITS_PER_CYC;
		end
	end

	assign sts.busy = run_q | (done_q & ~ctl.take);
	assign sts.done = done_q;

endmodule

### rtl/core/binary_to_decimal_digit_sequencer.sv
// Binary to decimal digit sequencer.
// Pulse start with a value while busy is low; the word is taken at that edge.
// The block returns one result per digit in use, most significant digit
// first: digit_index, bcd_digit, overflow and last, each shown for one cycle
// with strobe high. last marks the least significant digit. overflow is set
// in every result of a word whose value does not fit in the digits in use;
// the digits shown are then the low ones of the value.
// cfg_we with cfg_wdata sets the digit count (0 acts as 1, anything above
// MAX_DIGITS acts as MAX_DIGITS); write it only while idle.
// The results of a word follow on consecutive cycles. The conversion is a
// chain of BCD digit cells that take 4 bits of the value per cycle, and a
// digit buffer that plays the results out while the next word converts, so
// a new word can be taken before the results of the last one are all out.
// Reset clears all words in flight and sets the digit count to 4.
// Results cannot be held off: the receiver must take each strobe.
module binary_to_decimal_digit_sequencer #(
	parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [b2d_pkg::DCNT_W-1:0]    cfg_wdata,
	input  logic                          start,
	input  logic [b2d_pkg::VALUE_W-1:0]   value,
	output logic                          busy,
	output logic                          strobe,
	output logic [b2d_pkg::IDX_W-1:0]     digit_index,
	output logic [b2d_pkg::DIGIT_W-1:0]   bcd_digit,
	output logic                          overflow,
	output logic                          last
);
	import b2d_pkg::*;

	localparam int NCELL = ncell_f(MAX_DIGITS);
	localparam int PW    = $clog2(NCELL);

	logic [DCNT_W-1:0] dcnt_q;
	logic [DCNT_W-1:0] n_c;

	conv_ctl_t ctl;
	conv_sts_t sts;
	logic [NCELL-1:0][DIGIT_W-1:0] cdig;

	logic                          act_q;
	logic [PW-1:0]                 pos_q;
	logic [IDX_W-1:0]              k_q;
	logic                          ovf_q;
	logic [NCELL-1:0][DIGIT_W-1:0] dig_q;
	logic                          ovf_c;
	logic                          emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= DCNT_W'(DCNT_RST);
		end else if (cfg_we) begin
			dcnt_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (dcnt_q == '0) begin
			n_c = DCNT_W'(1);
		end else if (dcnt_q > DCNT_W'(MAX_DIGITS)) begin
			n_c = DCNT_W'(MAX_DIGITS);
		end else begin
			n_c = dcnt_q;
		end
	end

	assign emit_last = act_q && (pos_q == '0);
	assign ctl.take  = sts.done && (!act_q || emit_last);
	assign ctl.start = start && !busy;
	assign busy      = sts.busy;

	b2d_conv #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.value  (value),
		.sts    (sts),
		.digits (cdig)
	);

	// any nonzero digit above the ones in use means the value was cut
	always_comb begin
		ovf_c = 1'b0;
		for (int i = 0; i < NCELL; i++) begin
			if ((i >= int'(n_c)) && (cdig[i] != '0)) begin
				ovf_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			pos_q <= '0;
			k_q   <= '0;
		end else if (ctl.take) begin
			act_q <= 1'b1;
			pos_q <= PW'(n_c - 1'b1);
			k_q   <= '0;
		end else if (act_q) begin
			if (pos_q == '0) begin
				act_q <= 1'b0;
			end else begin
				pos_q <= pos_q - 1'b1;
				k_q   <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			dig_q <= cdig;
			ovf_q <= ovf_c;
		end
	end

	assign strobe      = act_q;
	assign digit_index = k_q;
	assign bcd_digit   = dig_q[pos_q];
	assign overflow    = ovf_q;
	assign last        = emit_last;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after a word was taken");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> digit_index == IDX_W'(n_c - 1'b1))
		else $error("last result not at the final digit index");

	a_bcd_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> bcd_digit <= DIGIT_W'(9))
		else $error("digit out of BCD range");

	a_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && digit_index == IDX_W'($past(digit_index) + 1'b1))
		else $error("digit sequence broken");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import b2d_pkg::*;

	localparam int unsigned VALUE_MAX    = 99_999_999;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned GAP_MAX      = 17;

	typedef struct {
		bit                 is_cfg;
		logic [DCNT_W-1:0]  dcnt;
		logic [VALUE_W-1:0] val;
		int unsigned        gap;
	} stim_t;

	typedef struct {
		logic [IDX_W-1:0]   idx;
		logic [DIGIT_W-1:0] bcd;
		logic               ovf;
		logic               lst;
	} digit_res_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [DCNT_W-1:0]   cfg_wdata = '0;
	logic                start     = 1'b0;
	logic [VALUE_W-1:0]  value     = '0;
	logic                busy;
	logic                strobe;
	logic [IDX_W-1:0]    digit_index;
	logic [DIGIT_W-1:0]  bcd_digit;
	logic                overflow;
	logic                last;

	stim_t       words_pending[$];
	digit_res_t  digits_due[$];
	int unsigned mismatches = 0;
	logic [DCNT_W-1:0] dcnt_shadow;
	int unsigned gap_left;
	int unsigned quiet_cycles;

	binary_to_decimal_digit_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.strobe     (strobe),
		.digit_index(digit_index),
		.bcd_digit  (bcd_digit),
		.overflow   (overflow),
		.last       (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned dec_power(int unsigned n);
		longint unsigned p;
		p = 1;
		for (int unsigned i = 0; i < n; i++)
			p = p * 10;
		return p;
	endfunction

	// expected digits of one word, most significant first
	function automatic void queue_bcd_digits(logic [VALUE_W-1:0] v, logic [DCNT_W-1:0] dcnt);
		int unsigned     n;
		longint unsigned lim;
		longint unsigned rest;
		digit_res_t      r;
		n = dcnt;
		if (n < 1)
			n = 1;
		if (n > MAX_DIGITS_DEF)
			n = MAX_DIGITS_DEF;
		lim  = dec_power(n);
		rest = v % lim;
		for (int unsigned k = 0; k < n; k++) begin
			r.idx = IDX_W'(k);
			r.bcd = DIGIT_W'((rest / dec_power(n - 1 - k)) % 10);
			r.ovf = (v >= lim);
			r.lst = (k == n - 1);
			digits_due.push_back(r);
		end
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: p = $urandom_range(0, VALUE_MAX);
			4, 5, 6: begin
				// land on either side of a power of ten
				p = dec_power($urandom_range(1, 8)) - 1 + $urandom_range(0, 2);
				if (p > VALUE_MAX)
					p = VALUE_MAX;
			end
			default: p = $urandom_range(0, 999);
		endcase
		return VALUE_W'(p);
	endfunction

	task automatic add_word(int unsigned v, int unsigned gap);
		stim_t s;
		s.is_cfg = 1'b0;
		s.dcnt   = '0;
		s.val    = VALUE_W'(v);
		s.gap    = gap;
		words_pending.push_back(s);
	endtask

	task automatic add_cfg(int unsigned dcnt);
		stim_t s;
		s.is_cfg = 1'b1;
		s.dcnt   = DCNT_W'(dcnt);
		s.val    = '0;
		s.gap    = 0;
		words_pending.push_back(s);
	endtask

	task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			value     <= '0;
			cfg_we    <= 1'b0;
			cfg_wdata <= '0;
			dcnt_shadow  = DCNT_W'(DCNT_RST);
			gap_left     = 0;
			quiet_cycles = 0;
		end else begin : drive
			logic               start_n;
			logic               we_n;
			logic [VALUE_W-1:0] value_n;
			logic [DCNT_W-1:0]  wdata_n;
			start_n = start;
			value_n = value;
			we_n    = 1'b0;
			wdata_n = cfg_wdata;
			if (start && !busy) begin
				queue_bcd_digits(value, dcnt_shadow);
				start_n  = 1'b0;
				gap_left = (words_pending.size() != 0) ? words_pending[0].gap : 0;
			end
			if (!start_n) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (words_pending.size() != 0) begin
					if (words_pending[0].is_cfg) begin
						// hold the write until every digit is out and the pipe is empty
						if (digits_due.size() != 0) begin
							quiet_cycles = 0;
						end else if (quiet_cycles < DRAIN_CYCLES) begin
							quiet_cycles++;
						end else begin
							we_n         = 1'b1;
							wdata_n      = words_pending[0].dcnt;
							dcnt_shadow  = wdata_n;
							quiet_cycles = 0;
							words_pending.pop_front();
							gap_left = (words_pending.size() != 0) ? words_pending[0].gap : 0;
						end
					end else begin
						start_n = 1'b1;
						value_n = words_pending[0].val;
						words_pending.pop_front();
					end
				end
			end
			start     <= start_n;
			value     <= value_n;
			cfg_we    <= we_n;
			cfg_wdata <= wdata_n;
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		digit_res_t exp_r;
		if (arst_n && strobe) begin
			if (digits_due.size() == 0) begin
				$error("digit with none due: digit_index %0d bcd_digit %0d",
					digit_index, bcd_digit);
				mismatches++;
			end else begin
				exp_r = digits_due.pop_front();
				report_field("digit_index", exp_r.idx, digit_index);
				report_field("bcd_digit", exp_r.bcd, bcd_digit);
				report_field("overflow", exp_r.ovf, overflow);
				report_field("last", exp_r.lst, last);
			end
		end
	end

	initial begin
		bit          steady;
		int unsigned dcnt;

		// reset digit count: edges of four digits and the largest test value
		add_word(0, 0);
		add_word(9999, 0);
		add_word(10000, 0);
		add_word(VALUE_MAX, 3);
		add_word(1234, 0);
		add_word(5678, GAP_MAX);
		add_word(1, 0);
		add_word(10, 1);
		add_word(1000, 0);
		// single digit
		add_cfg(1);
		add_word(0, 0);
		add_word(9, 0);
		add_word(10, 2);
		add_word(VALUE_MAX, 0);
		// all digits
		add_cfg(MAX_DIGITS_DEF);
		add_word(12345678, 0);
		add_word(VALUE_MAX, 0);
		add_word(10000000, 5);
		add_word(0, 0);
		add_word(1, 0);
		// zero count acts as one digit
		add_cfg(0);
		add_word(5, 0);
		add_word(42, 0);
		// oversized count saturates
		add_cfg(15);
		add_word(87654321, 0);
		add_word(VALUE_MAX, 0);

		for (int unsigned ph = 0; ph < 11; ph++) begin
			case (ph)
				0: dcnt = MAX_DIGITS_DEF;
				1: dcnt = 1;
				2: dcnt = 9;
				default: dcnt = $urandom_range(0, 15);
			endcase
			add_cfg(dcnt);
			steady = ($urandom_range(0, 3) == 0);
			for (int unsigned i = 0; i < 30; i++)
				add_word(pick_value(), steady ? 0 : $urandom_range(0, GAP_MAX));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (words_pending.size() != 0 || start || digits_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("binary_to_decimal_digit_sequencer: match");
		else
			$display("binary_to_decimal_digit_sequencer: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("binary_to_decimal_digit_sequencer: mismatch");
		$finish;
	end

endmodule
